>>> hw/rtl/atod_pkg.sv
// Package with shared constants and types of the occupancy detector.
package atod_pkg;
	localparam int CHANNELS_DEF = 32;
	localparam int WINDOW_DEF = 32;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int REG_ENABLED = 0;

	typedef struct packed {
		logic rej;
		logic [5:0] ch;
		logic [15:0] s;
	} cmd_t;
endpackage

>>> hw/rtl/atod_ram.sv
// Generic single-port RAM with registered read.
module atod_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

>>> hw/rtl/atod_front.sv
// Front part: accepts items, checks the channel index and queues commands.
module atod_front #(
	parameter int CHANNELS = 32,
	parameter int SAMPLE_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [4:0] detector_index,
	input logic [SAMPLE_BITS-1:0] sample,
	input logic [5:0] enabled,
	input logic cmd_take,
	output logic cmd_valid,
	output atod_pkg::cmd_t cmd
);
	import atod_pkg::*;
	logic [6:0] limit;
	cmd_t q0_q, q1_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;
	cmd_t nc;
	assign limit = ({1'b0, enabled} > 7'(CHANNELS)) ? 7'(CHANNELS) : {1'b0, enabled};
	assign full = cnt_q == 2'd2;
	assign do_push = push && !full;
	assign do_pop = cmd_take && cnt_q != 2'd0;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q0_q;
	always_comb begin
		nc.rej = {2'b00, detector_index} >= limit;
		nc.ch = {1'b0, detector_index};
		nc.s = 16'(sample);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
	always_ff @(posedge clk) begin
		if (do_pop) begin
			if (do_push && cnt_q == 2'd1) q0_q <= nc;
			else q0_q <= q1_q;
		end else if (do_push) begin
			if (cnt_q == 2'd0) q0_q <= nc;
			else q1_q <= nc;
		end
	end
endmodule

>>> hw/rtl/atod_back.sv
// Back part: updates channel state, divides serially and delivers results.
module atod_back #(
	parameter int CHANNELS = 32,
	parameter int WINDOW = 32,
	parameter int SAMPLE_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input atod_pkg::cmd_t cmd,
	output logic cmd_take,
	output logic empty,
	input logic pop,
	output logic accepted,
	output logic active,
	output logic [10:0] threshold,
	output logic [9:0] average,
	output logic [9:0] spread
);
	import atod_pkg::*;
	localparam int CB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WB = $clog2(WINDOW);
	localparam int NB = $clog2(WINDOW + 1);
	localparam int SUMB = SAMPLE_BITS + NB;
	localparam int AB = CB + WB;
	localparam int DEPTH = 2 ** AB;
	localparam int TB = SAMPLE_BITS + 2;
	localparam int SPK = 21;
	localparam int SP_MUL = 734004;

	typedef enum logic [4:0] {
		IDLE = 5'b00001, RD = 5'b00010, UPD = 5'b00100, DIV = 5'b01000, FIN = 5'b10000
	} st_t;
	st_t st_q;

	logic [WB-1:0] wpos_q [CHANNELS];
	logic [CHANNELS-1:0] wfull_q, lact_q;
	logic [SUMB-1:0] sum_q [CHANNELS];
	logic [SAMPLE_BITS-1:0] lo_q [CHANNELS];
	logic [SAMPLE_BITS-1:0] hi_q [CHANNELS];
	logic [TB-1:0] lth_q [CHANNELS];

	logic [CB-1:0] ch_q;
	logic [SAMPLE_BITS-1:0] s_q, rd_old;
	logic [SUMB-1:0] rem_q, quo_q, nsum_q;
	logic [NB-1:0] cnt_q;
	logic [$clog2(SUMB+1)-1:0] bit_q;
	logic [SAMPLE_BITS-1:0] sp_q;
	logic [SAMPLE_BITS-1:0] sp_frac_q;
	logic [SAMPLE_BITS+20:0] sp_prod;
	logic ram_we;
	logic [SAMPLE_BITS-1:0] ram_rd;
	logic [AB-1:0] addr;
	logic ovalid_q, oacc_q, oact_q;
	logic [10:0] oth_q;
	logic [9:0] oavg_q, osp_q;
	logic nsum_q_zero;

	assign addr = {ch_q, wpos_q[ch_q]};
	assign ram_we = st_q == UPD;
	atod_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(addr), .wdata(s_q), .rdata(ram_rd));
	assign rd_old = wfull_q[ch_q] ? ram_rd : '0;

	assign empty = !ovalid_q;
	assign accepted = oacc_q;
	assign active = oact_q;
	assign threshold = oth_q;
	assign average = oavg_q;
	assign spread = osp_q;
	assign cmd_take = st_q == IDLE && cmd_valid && !ovalid_q;
	assign nsum_q_zero = sum_q[ch_q] == '0;

	logic [SUMB-1:0] trial;
	logic [SAMPLE_BITS-1:0] nlo, nhi;
	logic [TB-1:0] th;
	assign trial = {rem_q[SUMB-2:0], nsum_q[SUMB-1]};
	assign sp_prod = (SAMPLE_BITS + 21)'(sp_q) * (SAMPLE_BITS + 21)'(SP_MUL);
	always_comb begin
		nlo = lo_q[ch_q];
		if (s_q != '0 && (nlo == '0 || s_q < nlo)) nlo = s_q;
		nhi = (s_q > hi_q[ch_q]) ? s_q : hi_q[ch_q];
		th = TB'(quo_q) + TB'(sp_frac_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			ovalid_q <= 1'b0;
			wfull_q <= '0;
			lact_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				wpos_q[i] <= '0; sum_q[i] <= '0; lo_q[i] <= '0;
				hi_q[i] <= '0; lth_q[i] <= '0;
			end
		end else begin
			if (pop && ovalid_q) ovalid_q <= 1'b0;
			case (st_q)
				IDLE: begin
					if (cmd_take) begin
						ch_q <= CB'(cmd.ch);
						s_q <= SAMPLE_BITS'(cmd.s);
						if (cmd.rej) begin
							ovalid_q <= 1'b1; oacc_q <= 1'b0; oact_q <= 1'b0;
							oth_q <= '0; oavg_q <= '0; osp_q <= '0;
						end else begin
							st_q <= RD;
						end
					end
				end
				RD: st_q <= UPD;
				UPD: begin
					nsum_q <= sum_q[ch_q] - SUMB'(rd_old) + SUMB'(s_q);
					sum_q[ch_q] <= sum_q[ch_q] - SUMB'(rd_old) + SUMB'(s_q);
					lo_q[ch_q] <= nlo; hi_q[ch_q] <= nhi;
					sp_q <= nhi - nlo;
					cnt_q <= wfull_q[ch_q] ? NB'(WINDOW) : NB'(wpos_q[ch_q]) + NB'(1);
					if (32'(wpos_q[ch_q]) == WINDOW - 1) begin
						wpos_q[ch_q] <= '0; wfull_q[ch_q] <= 1'b1;
					end else begin
						wpos_q[ch_q] <= wpos_q[ch_q] + WB'(1);
					end
					rem_q <= '0; quo_q <= '0;
					bit_q <= '0;
					st_q <= DIV;
				end
				DIV: begin
					if (trial >= SUMB'(cnt_q)) begin
						rem_q <= trial - SUMB'(cnt_q);
						quo_q <= {quo_q[SUMB-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[SUMB-2:0], 1'b0};
					end
					nsum_q <= nsum_q << 1;
					sp_frac_q <= sp_prod[SPK +: SAMPLE_BITS];
					if (32'(bit_q) == SUMB - 1) st_q <= FIN;
					bit_q <= bit_q + 1'b1;
				end
				FIN: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						oacc_q <= 1'b1;
						oavg_q <= 10'(quo_q);
						osp_q <= 10'(sp_q);
						if (nsum_q_zero) begin
							oth_q <= 11'(lth_q[ch_q]); oact_q <= lact_q[ch_q];
						end else begin
							lth_q[ch_q] <= th; lact_q[ch_q] <= TB'(s_q) > th;
							oth_q <= 11'(th); oact_q <= TB'(s_q) > th;
						end
						st_q <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/adaptive_threshold_occupancy_detector_top.sv
// Accepted items pass through RD, UPD, DIV (serial divider) and FIN; rejected items answer from IDLE.
// The back takes a new item only in IDLE and once the last result has been popped.
// A two-entry queue separates the front check from the back update.
// Asynchronous active-low reset clears all channel state and the register.
// Top level of the adaptive threshold occupancy detector.
module adaptive_threshold_occupancy_detector_top #(
	parameter int CHANNELS = atod_pkg::CHANNELS_DEF,
	parameter int WINDOW = atod_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = atod_pkg::SAMPLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic push,
	output logic full,
	input logic [4:0] detector_index,
	input logic [SAMPLE_BITS-1:0] sample,
	output logic empty,
	input logic pop,
	output logic accepted,
	output logic active,
	output logic [10:0] threshold,
	output logic [9:0] average,
	output logic [9:0] spread
);
	import atod_pkg::*;
	logic [5:0] en_q;
	logic cmd_valid, cmd_take;
	cmd_t cmd;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'(REG_ENABLED * 4)) ? {26'b0, en_q} : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (psel && penable && pwrite && paddr == 2'(REG_ENABLED * 4)) begin
			en_q <= pwdata[5:0];
		end
	end
	atod_front #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .push, .full, .detector_index, .sample, .enabled(en_q),
		.cmd_take, .cmd_valid, .cmd);
	atod_back #(.CHANNELS(CHANNELS), .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .empty, .pop,
		.accepted, .active, .threshold, .average, .spread);
endmodule

>>> hw/rtl/atod_checker.sv
// Port-level checker of the occupancy detector, bound to the top level.
module atod_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic accepted,
	input logic active,
	input logic [10:0] threshold,
	input logic [9:0] average
);
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !accepted |-> !active && threshold == 11'd0 && average == 10'd0)
		else $error("rejected item carries nonzero fields");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(threshold))
		else $error("waiting item changed");
	a_th: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && accepted |-> threshold <= 11'd1381)
		else $error("threshold out of range");
endmodule

bind adaptive_threshold_occupancy_detector_top atod_checker u_chk (.*);
